// ----- rtl/hcbd_pkg.sv -----
// shared types, character codes and hex decode for the chunked body decoder
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam int CAP_W   = 20;
    localparam int TOTAL_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 20'd65536;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LINE   = 2'd1,
        PH_CHUNK  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_ZERO_CHUNK = 2'd0,
        ST_INPUT_END  = 2'd1,
        ST_LINE_LONG  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } t_kind;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           out_byte;
        logic [TOTAL_W-1:0]   total_count;
        logic [1:0]           end_status;
        logic                 last_of_run;
    } t_result;

    // up to two results per byte, second only ever a report
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_core_res;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/http_chunked_body_decoder_unit.sv -----
// top level of the chunked transfer body decoder
`timescale 1ns / 1ps

// Takes a raw HTTP/1.1 response one byte per item and gives out the decoded chunked
// body. The header is skipped up to the first CR LF CR LF; each size line then gives a
// hex chunk size and that many following bytes come out as payload items (kind 0).
// Decoding ends with one report item (kind 1) carrying the saturating sum of declared
// chunk sizes and the reason: zero-size chunk or non-hex size line, end of input
// (is_last), or a size line with more than MAX_SIZE_DIGITS digits. After the report all
// bytes are accepted and dropped until reset. Payload beyond out_capacity bytes is
// consumed but not emitted. Rate: one byte per clock while the output side is ready;
// input stalls while the queue has fewer than two free entries. Each byte is decoded,
// with the state update, as it leaves the input register. Results go through a
// four-entry queue. Only the final byte can give two items (payload and report), so
// the output side keeps up at one item per clock. out_capacity is written through the
// cfg channel. The user must write it only while the block is idle; it is not enforced.

module http_chunked_body_decoder_unit #(
    parameter int MAX_SIZE_DIGITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_is_last,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [7:0]                 o_out_byte,
    output logic [31:0]                o_total_count,
    output logic [1:0]                 o_end_status,
    output logic                       o_last_of_run,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hcbd_pkg::CAP_W-1:0] i_cfg_out_capacity
);
    import hcbd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic      adv;
    logic      room;
    logic      done;
    logic [2:0] q_count;
    t_core_res core_res;
    t_result   head;

    // the held byte is decoded when the queue has room for two results
    assign adv         = r_in_valid && room;
    assign o_in_ready  = !r_in_valid || room;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
    end

    hcbd_core #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_cap (i_cfg_out_capacity),
        .o_res     (core_res),
        .o_done    (done)
    );

    hcbd_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_res   (core_res),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_head  (head),
        .o_room  (room),
        .o_count (q_count)
    );

    assign o_kind        = head.kind;
    assign o_out_byte    = head.out_byte;
    assign o_total_count = head.total_count;
    assign o_end_status  = head.end_status;
    assign o_last_of_run = head.last_of_run;

`ifndef ASSERT_OFF
    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= 3'd4)
        else $error("result queue overfilled");

    // nothing is produced once decoding has ended
    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !core_res.v0)
        else $error("result after end of decoding");

    // a second result only together with a first one, and it ends the run
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_res.v1 |-> (core_res.v0 && core_res.r0.kind == KIND_PAYLOAD
                         && core_res.r1.kind == KIND_REPORT))
        else $error("bad result pair");

    // a report always moves the decoder to its end
    a_report_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && core_res.v0 && core_res.r0.kind == KIND_REPORT) |=> done)
        else $error("report without end of decoding");
`endif

endmodule

// ----- rtl/hcbd_core.sv -----
// decode state and per-byte result logic of the chunked body decoder
`timescale 1ns / 1ps

module hcbd_core #(
    parameter int MAX_SIZE_DIGITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [7:0]                 i_byte,
    input  logic                       i_last,
    input  logic                       i_cfg_we,
    input  logic [hcbd_pkg::CAP_W-1:0] i_cfg_cap,
    output hcbd_pkg::t_core_res        o_res,
    output logic                       o_done
);
    import hcbd_pkg::*;

    localparam int DCW = $clog2(MAX_SIZE_DIGITS + 1);

    t_phase             r_phase, n_phase;
    logic [1:0]         r_tm, n_tm;
    logic [31:0]        r_acc, n_acc;
    logic [DCW-1:0]     r_dc, n_dc;
    logic               r_he, n_he;
    logic               r_ne, n_ne;
    logic [31:0]        r_rem, n_rem;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CAP_W-1:0]   r_written, n_written;
    logic [CAP_W-1:0]   r_cap;

    always_comb begin
        logic        fin;
        logic [1:0]  fin_st;
        logic        pay;
        logic        hit;
        logic [32:0] sum;
        t_hex        h;
        t_result     rp;
        t_result     rr;

        n_phase   = r_phase;
        n_tm      = r_tm;
        n_acc     = r_acc;
        n_dc      = r_dc;
        n_he      = r_he;
        n_ne      = r_ne;
        n_rem     = r_rem;
        n_total   = r_total;
        n_written = r_written;
        fin       = 1'b0;
        fin_st    = ST_INPUT_END;
        pay       = 1'b0;
        h         = hex_decode(i_byte);
        hit       = (i_byte == (r_tm[0] ? CHAR_LF : CHAR_CR));
        sum       = {1'b0, r_total} + {1'b0, r_acc};

        unique case (r_phase)
            PH_HEADER: begin
                if (hit) begin
                    if (r_tm == 2'd3) begin
                        n_phase = PH_LINE;
                        n_tm    = 2'd0;
                        n_acc   = '0;
                        n_dc    = '0;
                        n_he    = 1'b0;
                        n_ne    = 1'b0;
                    end else begin
                        n_tm = r_tm + 2'd1;
                    end
                end else begin
                    n_tm = (i_byte == CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_LINE: begin
                if (r_tm[0]) begin
                    n_tm = 2'd0;
                    if (i_byte == CHAR_LF) begin
                        if (!r_ne) begin
                            n_acc = '0;
                            n_dc  = '0;
                            n_he  = 1'b0;
                        end else if (r_dc == '0 || r_acc == '0) begin
                            fin    = 1'b1;
                            fin_st = ST_ZERO_CHUNK;
                        end else begin
                            n_rem   = r_acc;
                            n_total = sum[32] ? '1 : sum[31:0];
                            n_phase = PH_CHUNK;
                        end
                    end else begin
                        // lone cr: line content, no more size digits
                        n_tm = (i_byte == CHAR_CR) ? 2'd1 : 2'd0;
                        n_ne = 1'b1;
                        n_he = 1'b1;
                    end
                end else if (i_byte == CHAR_CR) begin
                    n_tm = 2'd1;
                end else begin
                    n_ne = 1'b1;
                    if (!r_he) begin
                        if (!h.ok) begin
                            n_he = 1'b1;
                        end else if (r_dc >= DCW'(MAX_SIZE_DIGITS)) begin
                            fin    = 1'b1;
                            fin_st = ST_LINE_LONG;
                        end else begin
                            n_acc = {r_acc[27:0], h.val};
                            n_dc  = r_dc + DCW'(1);
                        end
                    end
                end
            end
            PH_CHUNK: begin
                if (r_written < r_cap) begin
                    pay       = 1'b1;
                    n_written = r_written + CAP_W'(1);
                end
                if (r_rem <= 32'd1) begin
                    n_rem   = '0;
                    n_phase = PH_LINE;
                    n_tm    = 2'd0;
                    n_acc   = '0;
                    n_dc    = '0;
                    n_he    = 1'b0;
                    n_ne    = 1'b0;
                end else begin
                    n_rem = r_rem - 32'd1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (r_phase != PH_DONE && !fin && i_last) begin
            fin    = 1'b1;
            fin_st = ST_INPUT_END;
        end
        if (fin) begin
            n_phase = PH_DONE;
        end

        rp.kind        = KIND_PAYLOAD;
        rp.out_byte    = i_byte;
        rp.total_count = '0;
        rp.end_status  = ST_ZERO_CHUNK;
        rp.last_of_run = !fin;

        rr.kind        = KIND_REPORT;
        rr.out_byte    = 8'd0;
        rr.total_count = n_total;
        rr.end_status  = fin_st;
        rr.last_of_run = 1'b1;

        o_res.v0 = pay || fin;
        o_res.v1 = pay && fin;
        o_res.r0 = pay ? rp : rr;
        o_res.r1 = rr;
    end

    assign o_done = (r_phase == PH_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_tm      <= '0;
            r_acc     <= '0;
            r_dc      <= '0;
            r_he      <= 1'b0;
            r_ne      <= 1'b0;
            r_rem     <= '0;
            r_total   <= '0;
            r_written <= '0;
            r_cap     <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_cap;
            end
            if (i_adv) begin
                r_phase   <= n_phase;
                r_tm      <= n_tm;
                r_acc     <= n_acc;
                r_dc      <= n_dc;
                r_he      <= n_he;
                r_ne      <= n_ne;
                r_rem     <= n_rem;
                r_total   <= n_total;
                r_written <= n_written;
            end
        end
    end

endmodule

// ----- rtl/hcbd_res_queue.sv -----
// four-entry result queue, takes up to two results per cycle, gives one
`timescale 1ns / 1ps

module hcbd_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hcbd_pkg::t_core_res i_res,
    input  logic                i_pop,
    output logic                o_valid,
    output hcbd_pkg::t_result   o_head,
    output logic                o_room,
    output logic [2:0]          o_count
);
    import hcbd_pkg::*;

    t_result    r_slot [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;
    logic       w0, w1;
    logic [1:0] wr1;

    assign w0      = i_push && i_res.v0;
    assign w1      = i_push && i_res.v1;
    assign wr1     = r_wr + 2'd1;
    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_slot[r_rd];
    assign o_room  = (r_count <= 3'd2);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (w0 && r_wr == 2'(k)) begin
                r_slot[k] <= i_res.r0;
            end else if (w1 && wr1 == 2'(k)) begin
                r_slot[k] <= i_res.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + 2'({1'b0, w0} + {1'b0, w1});
            r_rd    <= r_rd + 2'(i_pop && o_valid);
            r_count <= r_count + 3'({1'b0, w0} + {1'b0, w1}) - 3'(i_pop && o_valid);
        end
    end

endmodule
